@@ design/lra_pkg.sv @@
// shared constants and types for the letterbox resize address core
`default_nettype none
package lra_pkg;

  // field and register widths
  localparam int COORD_W = 12;
  localparam int CFG_W   = 13;
  localparam int DIM_W   = 14;
  localparam int IDX_W   = 24;
  localparam int PAD_W   = 12;
  localparam int REG_W   = 2;

  // stream payload widths
  localparam int S_TDATA_W = 2 * COORD_W;
  localparam int M_TDATA_W = 2 * IDX_W + 2 * PAD_W;

  // pixel divider geometry: local coordinate times source size over target size
  localparam int DIV_NW = COORD_W + DIM_W;
  localparam int DIV_TW = 1 + IDX_W;

  localparam int MAX_DIM_DEFAULT = 4096;

  // register indexes
  localparam logic [REG_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [REG_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
  localparam logic [REG_W-1:0] REG_TARGET_WIDTH  = 2'd2;
  localparam logic [REG_W-1:0] REG_TARGET_HEIGHT = 2'd3;

  // register reset values
  localparam logic [CFG_W-1:0] RST_SOURCE_WIDTH  = 13'd1280;
  localparam logic [CFG_W-1:0] RST_SOURCE_HEIGHT = 13'd720;
  localparam logic [CFG_W-1:0] RST_TARGET_WIDTH  = 13'd640;
  localparam logic [CFG_W-1:0] RST_TARGET_HEIGHT = 13'd640;

  // derived geometry handed from the setup unit to the pixel pipeline
  typedef struct packed {
    logic [DIM_W-1:0] src_w;
    logic [DIM_W-1:0] src_h;
    logic [DIM_W-1:0] tgt_w;
    logic [DIM_W-1:0] num;
    logic [DIM_W-1:0] den;
    logic [DIM_W-1:0] cont_w;
    logic [DIM_W-1:0] cont_h;
    logic [PAD_W-1:0] pad_l;
    logic [PAD_W-1:0] pad_t;
  } geom_t;

endpackage
`default_nettype wire

@@ design/lra_setup.sv @@
// configuration registers and sequential derivation of scale, content size and margins
`default_nettype none
module lra_setup #(
  parameter int MAX_DIM = lra_pkg::MAX_DIM_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [lra_pkg::REG_W-1:0] cfg_addr,
  input  wire logic [lra_pkg::CFG_W-1:0] cfg_data,
  output lra_pkg::geom_t                 geom,
  output logic                           busy
);

  localparam int DW  = lra_pkg::DIM_W;
  localparam int PW  = 2 * DW;
  localparam int DDW = 2 * DW + 1;
  localparam int KW  = $clog2(DW);

  typedef enum logic [2:0] {
    ST_IDLE, ST_PROD, ST_SCALE, ST_MULT, ST_DIV, ST_FIN
  } state_t;

  state_t state;

  logic [lra_pkg::CFG_W-1:0] src_w_reg, src_h_reg, tgt_w_reg, tgt_h_reg;
  logic [DW-1:0]  sw, sh, tw, th;
  logic [PW-1:0]  prod_a, prod_b;
  logic [DW-1:0]  num, den;
  logic [DDW-1:0] rem_w, rem_h;
  logic [DW:0]    dvs;
  logic [KW-1:0]  bit_idx;
  logic [DW-1:0]  quot_w, quot_h;
  logic [DW-1:0]  cont_w, cont_h;
  logic [lra_pkg::PAD_W-1:0] pad_l, pad_t;
  logic [DDW-1:0] trial;
  logic           ge_w, ge_h;
  logic           wl;

  // zero counts as one, oversize saturates at the maximum dimension
  function automatic logic [DW-1:0] eff(input logic [lra_pkg::CFG_W-1:0] v);
    logic [DW-1:0] r;
    if (v == '0) begin
      r = DW'(1);
    end else if (DW'(v) > DW'(MAX_DIM)) begin
      r = DW'(MAX_DIM);
    end else begin
      r = DW'(v);
    end
    return r;
  endfunction

  assign sw = eff(src_w_reg);
  assign sh = eff(src_h_reg);
  assign tw = eff(tgt_w_reg);
  assign th = eff(tgt_h_reg);

  assign wl    = (prod_a <= prod_b);
  assign trial = DDW'(dvs) << bit_idx;
  assign ge_w  = (rem_w >= trial);
  assign ge_h  = (rem_h >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_PROD;
      src_w_reg <= lra_pkg::RST_SOURCE_WIDTH;
      src_h_reg <= lra_pkg::RST_SOURCE_HEIGHT;
      tgt_w_reg <= lra_pkg::RST_TARGET_WIDTH;
      tgt_h_reg <= lra_pkg::RST_TARGET_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        lra_pkg::REG_SOURCE_WIDTH:  src_w_reg <= cfg_data;
        lra_pkg::REG_SOURCE_HEIGHT: src_h_reg <= cfg_data;
        lra_pkg::REG_TARGET_WIDTH:  tgt_w_reg <= cfg_data;
        lra_pkg::REG_TARGET_HEIGHT: tgt_h_reg <= cfg_data;
      endcase
      state <= ST_PROD;
    end else begin
      unique case (state)
        ST_IDLE: begin
        end
        // cross products decide which axis limits the scale
        ST_PROD: begin
          prod_a <= PW'(tw) * PW'(sh);
          prod_b <= PW'(th) * PW'(sw);
          state  <= ST_SCALE;
        end
        ST_SCALE: begin
          num   <= wl ? tw : th;
          den   <= wl ? sw : sh;
          state <= ST_MULT;
        end
        // rounded scaled size: (2 * size * num + den) / (2 * den)
        ST_MULT: begin
          rem_w   <= ((DDW'(sw) * DDW'(num)) << 1) + DDW'(den);
          rem_h   <= ((DDW'(sh) * DDW'(num)) << 1) + DDW'(den);
          dvs     <= {den, 1'b0};
          quot_w  <= '0;
          quot_h  <= '0;
          bit_idx <= KW'(DW - 1);
          state   <= ST_DIV;
        end
        // one quotient bit per cycle for both axes
        ST_DIV: begin
          if (ge_w) begin
            rem_w <= rem_w - trial;
          end
          if (ge_h) begin
            rem_h <= rem_h - trial;
          end
          quot_w[bit_idx] <= ge_w;
          quot_h[bit_idx] <= ge_h;
          if (bit_idx == '0) begin
            state <= ST_FIN;
          end else begin
            bit_idx <= bit_idx - KW'(1);
          end
        end
        // margins use the size before a zero content is raised to one
        ST_FIN: begin
          pad_l  <= (quot_w < tw) ? lra_pkg::PAD_W'((tw - quot_w) >> 1) : '0;
          pad_t  <= (quot_h < th) ? lra_pkg::PAD_W'((th - quot_h) >> 1) : '0;
          cont_w <= (quot_w == '0) ? DW'(1) : quot_w;
          cont_h <= (quot_h == '0) ? DW'(1) : quot_h;
          state  <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign busy = (state != ST_IDLE);

  always_comb begin
    geom.src_w  = sw;
    geom.src_h  = sh;
    geom.tgt_w  = tw;
    geom.num    = num;
    geom.den    = den;
    geom.cont_w = cont_w;
    geom.cont_h = cont_h;
    geom.pad_l  = pad_l;
    geom.pad_t  = pad_t;
  end

endmodule
`default_nettype wire

@@ design/lra_div_pipe.sv @@
// pipelined restoring divider, one quotient bit per stage, saturation flag on overflow
`default_nettype none
module lra_div_pipe #(
  parameter int LANES = 2,
  parameter int NW    = lra_pkg::DIV_NW,
  parameter int DW    = lra_pkg::DIM_W,
  parameter int QW    = lra_pkg::DIM_W,
  parameter int TW    = lra_pkg::DIV_TW
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] in_num [LANES],
  input  wire logic [DW-1:0] divisor,
  input  wire logic [TW-1:0] in_tag,
  output logic               out_valid,
  output logic [QW-1:0]      out_quot [LANES],
  output logic               out_sat [LANES],
  output logic [TW-1:0]      out_tag
);

  localparam int CW = ((NW > DW + QW) ? NW : DW + QW) + 1;

  logic          valid [QW+1];
  logic [NW-1:0] rem   [QW][LANES];
  logic [QW-1:0] quot  [QW+1][LANES];
  logic          sat   [QW+1][LANES];
  logic [TW-1:0] tag   [QW+1];

  // entry stage: flag a quotient that would not fit, so the caller clamps
  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else if (en) begin
      valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag[0] <= in_tag;
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_entry
    always_ff @(posedge clk) begin
      if (en) begin
        rem[0][l]  <= in_num[l];
        quot[0][l] <= '0;
        sat[0][l]  <= (CW'(in_num[l]) >= (CW'(divisor) << QW));
      end
    end
  end

  for (genvar j = 1; j <= QW; j++) begin : g_stage
    localparam int B = QW - j;
    logic [CW-1:0] trial;

    assign trial = CW'(divisor) << B;

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[j] <= 1'b0;
      end else if (en) begin
        valid[j] <= valid[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag[j] <= tag[j-1];
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic          ge;
      logic [QW-1:0] q_next;

      assign ge = (CW'(rem[j-1][l]) >= trial);

      always_comb begin
        q_next    = quot[j-1][l];
        q_next[B] = ge;
      end

      always_ff @(posedge clk) begin
        if (en) begin
          quot[j][l] <= q_next;
          sat[j][l]  <= sat[j-1][l];
        end
      end

      if (j < QW) begin : g_rem
        always_ff @(posedge clk) begin
          if (en) begin
            rem[j][l] <= ge ? NW'(CW'(rem[j-1][l]) - trial) : rem[j-1][l];
          end
        end
      end
    end
  end

  assign out_valid = valid[QW];
  assign out_tag   = tag[QW];

  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign out_quot[l] = quot[QW][l];
    assign out_sat[l]  = sat[QW][l];
  end

endmodule
`default_nettype wire

@@ design/lra_out_buf.sv @@
// output register with one skid entry so the pipeline runs while a result waits
`default_nettype none
module lra_out_buf #(
  parameter int W = lra_pkg::M_TDATA_W + 1
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  input  wire logic [W-1:0] in_data,
  output logic              space,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [W-1:0]      out_data
);

  logic         skid_valid;
  logic [W-1:0] skid_data;
  logic         take;

  assign take  = out_valid && out_ready;
  assign space = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (in_valid) begin
      if (!out_valid || take) begin
        out_data  <= in_data;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= in_data;
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

@@ design/letterbox_resize_address_core.sv @@
// top level of the letterbox nearest-neighbor resize address generator
`default_nettype none
// Letterbox resize address generator. The four size registers set one scale, the smaller of
// target/source width and height, held as an exact ratio; the content size is the rounded
// scaled size and the left and top padding are half the slack, rounded down. Each item on the
// slave stream is one destination coordinate; each result item says whether that pixel is gray
// padding (tuser high) or content, and for content gives the source pixel index, nearest
// neighbor, clamped to the source edge. The destination index and both pads come with every
// item. Size values of zero count as one and values above MAX_DIM count as MAX_DIM. After reset
// and after every register write the setup unit derives the geometry, during which s_tready
// is low. After that one item is accepted per cycle while the skid has room; an item passes
// stages a, b, c, the 15-stage pixel divider (an entry stage, then one quotient bit per stage),
// stages e, f, p and the output register. A one-entry skid behind the output register keeps
// the pipeline moving while a result waits; the pipeline halts only once that skid is full.
module letterbox_resize_address_core #(
  parameter int MAX_DIM = lra_pkg::MAX_DIM_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration write port
  input  wire logic                          cfg_we,
  input  wire logic [lra_pkg::REG_W-1:0]     cfg_addr,
  input  wire logic [lra_pkg::CFG_W-1:0]     cfg_data,
  // coordinate stream
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [lra_pkg::S_TDATA_W-1:0] s_tdata,  // dest_col, dest_row
  // address stream
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [lra_pkg::M_TDATA_W-1:0]      m_tdata,  // source_index, dest_index, pad_left, pad_top
  output logic                               m_tuser   // is_fill
);

  localparam int CRW = lra_pkg::COORD_W;
  localparam int DW  = lra_pkg::DIM_W;
  localparam int NW  = lra_pkg::DIV_NW;
  localparam int IW  = lra_pkg::IDX_W;
  localparam int PW  = 2 * DW;
  localparam int OW  = lra_pkg::M_TDATA_W + 1;

  lra_pkg::geom_t geom;
  logic           busy;
  logic           en;

  // stage a: captured coordinate
  logic           a_valid;
  logic [CRW-1:0] a_col, a_row;
  // stage b: content-local coordinates and the destination row product
  logic           b_valid;
  logic [CRW-1:0] b_col, b_lx, b_ly;
  logic           b_in;
  logic [NW-1:0]  b_dprod;
  // stage c: dividends and the finished destination index
  logic           c_valid;
  logic [NW-1:0]  c_num [2];
  logic [IW:0]    c_tag;
  // divider output
  logic           d_valid;
  logic [DW-1:0]  d_quot [2];
  logic           d_sat [2];
  logic [IW:0]    d_tag;
  // stage e: clamped source coordinates
  logic           e_valid;
  logic [DW-1:0]  e_sx, e_sy;
  logic [IW:0]    e_tag;
  // stage f: source row product
  logic           f_valid;
  logic [DW-1:0]  f_sx;
  logic [PW-1:0]  f_prod;
  logic [IW:0]    f_tag;
  // stage p: packed result ahead of the output buffer
  logic           p_valid;
  logic [OW-1:0]  p_data;
  logic [OW-1:0]  out_data;

  logic [CRW-1:0] lx, ly;
  logic           in_x, in_y;

  lra_setup #(
    .MAX_DIM (MAX_DIM)
  ) u_setup (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .geom     (geom),
    .busy     (busy)
  );

  // the whole pipeline advances together whenever the skid entry is free
  assign s_tready = en && !busy;

  // a coordinate left of or above the margin wraps and fails the content compare
  assign lx   = a_col - geom.pad_l;
  assign ly   = a_row - geom.pad_t;
  assign in_x = (a_col >= geom.pad_l) && (DW'(lx) < geom.cont_w);
  assign in_y = (a_row >= geom.pad_t) && (DW'(ly) < geom.cont_h);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      e_valid <= 1'b0;
      f_valid <= 1'b0;
      p_valid <= 1'b0;
    end else if (en) begin
      a_valid <= s_tvalid && !busy;
      b_valid <= a_valid;
      c_valid <= b_valid;
      e_valid <= d_valid;
      f_valid <= e_valid;
      p_valid <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_col <= s_tdata[CRW-1:0];
      a_row <= s_tdata[2*CRW-1:CRW];

      b_col   <= a_col;
      b_lx    <= lx;
      b_ly    <= ly;
      b_in    <= in_x && in_y;
      b_dprod <= NW'(a_row) * NW'(geom.tgt_w);

      // source coordinate = floor(local * den / num)
      c_num[0] <= NW'(b_lx) * NW'(geom.den);
      c_num[1] <= NW'(b_ly) * NW'(geom.den);
      c_tag    <= {!b_in, IW'(b_dprod + NW'(b_col))};

      // clamp to the source edge, also when the quotient overflowed
      e_sx  <= (d_sat[0] || (d_quot[0] >= geom.src_w)) ? geom.src_w - DW'(1) : d_quot[0];
      e_sy  <= (d_sat[1] || (d_quot[1] >= geom.src_h)) ? geom.src_h - DW'(1) : d_quot[1];
      e_tag <= d_tag;

      f_sx   <= e_sx;
      f_prod <= PW'(e_sy) * PW'(geom.src_w);
      f_tag  <= e_tag;

      // padding pixels report source index zero
      p_data <= {f_tag[IW], geom.pad_t, geom.pad_l, f_tag[IW-1:0],
                 f_tag[IW] ? IW'(0) : IW'(f_prod + PW'(f_sx))};
    end
  end

  lra_div_pipe #(
    .LANES (2),
    .NW    (NW),
    .DW    (DW),
    .QW    (DW),
    .TW    (IW + 1)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (c_valid),
    .in_num    (c_num),
    .divisor   (geom.num),
    .in_tag    (c_tag),
    .out_valid (d_valid),
    .out_quot  (d_quot),
    .out_sat   (d_sat),
    .out_tag   (d_tag)
  );

  lra_out_buf #(
    .W (OW)
  ) u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (p_valid),
    .in_data   (p_data),
    .space     (en),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_data)
  );

  assign m_tdata = out_data[OW-2:0];
  assign m_tuser = out_data[OW-1];

endmodule
`default_nettype wire
